[src/kle_pkg.sv]
// kle_pkg: shared constants, codes and the control state type of the
// k-means engine; used by the top level and kle_chk, depends on nothing
package kle_pkg;

  localparam int DEF_MAX_CLUSTERS      = 64;
  localparam int DEF_MAX_VECTOR_LENGTH = 64;
  localparam int DEF_VALUE_BITS        = 16;
  localparam int DEF_COUNT_BITS        = 24;

  // command codes
  localparam logic [1:0] CMD_LOAD   = 2'd0;
  localparam logic [1:0] CMD_ASSIGN = 2'd1;
  localparam logic [1:0] CMD_UPDATE = 2'd2;
  localparam logic [1:0] CMD_RSVD   = 2'd3;

  // configuration register indexes
  localparam logic REG_CLUSTER_COUNT = 1'b0;
  localparam logic REG_VECTOR_LENGTH = 1'b1;

  // result kinds
  localparam logic RES_ASSIGN = 1'b0;
  localparam logic RES_UPDATE = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIST,
    ST_DRAIN,
    ST_ACC,
    ST_ACC_END,
    ST_UPD_CNT,
    ST_UPD_CHK,
    ST_UPD_RD,
    ST_UPD_START,
    ST_UPD_DIV,
    ST_UPD_END,
    ST_DONE
  } kle_state_t;

endpackage

[src/kle_ram.sv]
// kle_ram: generic simple dual-port ram, one write and one registered read
// port; no dependencies
module kle_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[src/kle_div.sv]
// kle_div: restoring divider, one quotient bit per cycle
// no dependencies; used by the update walk of the engine
module kle_div #(
  parameter int NUM_BITS = 41,
  parameter int DEN_BITS = 24
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [NUM_BITS-1:0] num,
  input  logic [DEN_BITS-1:0] den,
  output logic                done,
  output logic [NUM_BITS-1:0] quo
);

  localparam int STEP_BITS = $clog2(NUM_BITS + 1);

  logic [STEP_BITS-1:0] step_r;
  logic                 busy_r;
  logic                 done_r;
  logic [NUM_BITS-1:0]  q_r;
  logic [DEN_BITS-1:0]  rem_r;
  logic [DEN_BITS-1:0]  den_r;
  logic [DEN_BITS:0]    trial;
  logic                 fits;

  assign trial = {rem_r, q_r[NUM_BITS-1]};
  assign fits  = trial >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= STEP_BITS'(NUM_BITS);
      end else if (busy_r) begin
        step_r <= step_r - 1'b1;
        if (step_r == STEP_BITS'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= num;
      rem_r <= '0;
      den_r <= den;
    end else if (busy_r) begin
      rem_r <= fits ? DEN_BITS'(trial - {1'b0, den_r}) : trial[DEN_BITS-1:0];
      q_r   <= {q_r[NUM_BITS-2:0], fits};
    end
  end

  assign done = done_r;
  assign quo  = q_r;

endmodule

[src/kmeans_lloyd_engine_unit.sv]
// kmeans_lloyd_engine_unit: top level of the lloyd k-means engine
// uses kle_pkg, kle_ram (centroid, sample, sum and count stores), kle_div
//
//  channel | direction | transaction
//  in_     | slave     | one command: load element, assign sample element, update
//  out_    | master    | assignment result or update summary
//  cfg_    | slave     | write of cluster_count (index 0) or vector_length (index 1)
//
// a load or an assign without the last mark is taken in idle, and the engine stays there
// a last sample element starts the distance walk over k*len elements, then, when accumulating,
// a walk over len elements (MAX_VECTOR_LENGTH for a cluster's first sample), then the result
// is handed over; the single centroid read port sets the pace, one element per cycle
// an update walks every cluster and divides each element of a non-empty cluster
// with the one-bit-per-cycle divider; reset needs no clearing pass
// a waiting result blocks in_tready only while the next result is held in the done state
module kmeans_lloyd_engine_unit #(
  parameter int MAX_CLUSTERS      = kle_pkg::DEF_MAX_CLUSTERS,
  parameter int MAX_VECTOR_LENGTH = kle_pkg::DEF_MAX_VECTOR_LENGTH,
  parameter int VALUE_BITS        = kle_pkg::DEF_VALUE_BITS,
  parameter int COUNT_BITS        = kle_pkg::DEF_COUNT_BITS,
  localparam int CW    = $clog2(MAX_CLUSTERS),
  localparam int LW    = (MAX_VECTOR_LENGTH > 1) ? $clog2(MAX_VECTOR_LENGTH) : 1,
  localparam int KW    = $clog2(MAX_CLUSTERS + 1),
  localparam int NW    = $clog2(MAX_VECTOR_LENGTH + 1),
  localparam int CFG_W = (KW > NW) ? KW : NW,
  localparam int DIST_BITS = 2 * VALUE_BITS + 6,
  localparam int IN_W  = ((2 + CW + LW + VALUE_BITS + 7) / 8) * 8,
  localparam int OUT_W = ((CW + DIST_BITS + KW + 7) / 8) * 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [IN_W-1:0]  in_tdata,   // command, cluster_index, element_index, element_value
  input  logic             in_tlast,
  input  logic             in_tuser,   // accumulate
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [OUT_W-1:0] out_tdata,  // nearest_cluster, squared_distance, empty_clusters
  output logic             out_tuser,  // result_kind
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic             cfg_addr,
  input  logic [CFG_W-1:0] cfg_data
);

  localparam int SUM_BITS = VALUE_BITS + COUNT_BITS;
  localparam int AW       = CW + LW;
  localparam int DEPTH    = MAX_CLUSTERS << LW;
  localparam int NB       = SUM_BITS + 1;

  kle_pkg::kle_state_t state_r, state_nxt;

  // input fields
  logic [1:0]            in_cmd;
  logic [CW-1:0]         in_ci;
  logic [LW-1:0]         in_ei;
  logic [VALUE_BITS-1:0] in_val;
  logic                  in_fire;

  assign in_cmd  = in_tdata[1:0];
  assign in_ci   = in_tdata[2 +: CW];
  assign in_ei   = in_tdata[2 + CW +: LW];
  assign in_val  = in_tdata[2 + CW + LW +: VALUE_BITS];
  assign in_fire = in_tvalid && in_tready;

  logic ci_ok, ei_ok;
  assign ci_ok = {1'b0, in_ci} < (CW + 1)'(MAX_CLUSTERS);
  assign ei_ok = {1'b0, in_ei} < (LW + 1)'(MAX_VECTOR_LENGTH);

  // configuration
  logic [KW-1:0] k_r;
  logic [NW-1:0] len_r;

  assign cfg_ready = 1'b1;

  // control and counters
  logic [CW-1:0]         c_r;
  logic [LW-1:0]         j_r;
  logic                  acc_r;
  logic [KW-1:0]         empty_r;
  logic [CW-1:0]         best_r;
  logic [DIST_BITS-1:0]  best_d_r;
  logic [DIST_BITS-1:0]  d_r;
  logic [MAX_CLUSTERS-1:0] rv_r;
  logic [COUNT_BITS-1:0] cnt_r;
  logic                  neg_r;

  logic j_last, c_last, acc_last;
  logic [NW-1:0] acc_end;

  assign j_last   = (NW'(j_r) + NW'(1)) == len_r;
  assign c_last   = (KW'(c_r) + KW'(1)) == k_r;
  assign acc_end  = rv_r[best_r] ? len_r : NW'(MAX_VECTOR_LENGTH);
  assign acc_last = (NW'(j_r) + NW'(1)) == acc_end;

  // distance pipeline tags
  logic                 p1_v_r, p1_first_r, p1_last_r;
  logic [CW-1:0]        p1_c_r;
  logic                 p2_v_r, p2_first_r, p2_last_r;
  logic [CW-1:0]        p2_c_r;
  logic [DIST_BITS-1:0] sq_r;

  // accumulate stage
  logic          a1_v_r, a1_use_r;
  logic [LW-1:0] a1_j_r;

  // memory ports
  logic                  cen_we;
  logic [AW-1:0]         cen_waddr;
  logic [VALUE_BITS-1:0] cen_wdata, cen_rd;
  logic                  samp_we;
  logic [VALUE_BITS-1:0] samp_rd;
  logic [AW-1:0]         sum_raddr;
  logic [SUM_BITS-1:0]   sum_wdata, sum_rd;
  logic [CW-1:0]         cnt_raddr;
  logic                  cnt_we;
  logic [COUNT_BITS-1:0] cnt_wdata, cnt_rd;

  kle_ram #(.WIDTH(VALUE_BITS), .DEPTH(DEPTH)) u_cen_ram (
    .clk(clk), .we(cen_we), .waddr(cen_waddr), .wdata(cen_wdata),
    .raddr({c_r, j_r}), .rdata(cen_rd)
  );

  kle_ram #(.WIDTH(VALUE_BITS), .DEPTH(1 << LW)) u_samp_ram (
    .clk(clk), .we(samp_we), .waddr(in_ei), .wdata(in_val),
    .raddr(j_r), .rdata(samp_rd)
  );

  kle_ram #(.WIDTH(SUM_BITS), .DEPTH(DEPTH)) u_sum_ram (
    .clk(clk), .we(a1_v_r), .waddr({best_r, a1_j_r}), .wdata(sum_wdata),
    .raddr(sum_raddr), .rdata(sum_rd)
  );

  kle_ram #(.WIDTH(COUNT_BITS), .DEPTH(MAX_CLUSTERS)) u_cnt_ram (
    .clk(clk), .we(cnt_we), .waddr(best_r), .wdata(cnt_wdata),
    .raddr(cnt_raddr), .rdata(cnt_rd)
  );

  assign samp_we   = in_fire && in_cmd == kle_pkg::CMD_ASSIGN && ei_ok;
  assign sum_raddr = (state_r == kle_pkg::ST_ACC) ? {best_r, j_r} : {c_r, j_r};
  assign cnt_raddr = (state_r == kle_pkg::ST_ACC || state_r == kle_pkg::ST_ACC_END) ?
                     best_r : c_r;

  // distance: difference, square, saturating sum
  logic signed [VALUE_BITS:0] diff;
  logic [VALUE_BITS:0]        mag;
  logic [DIST_BITS:0]         d_add;
  logic [DIST_BITS-1:0]       d_cur;

  assign diff  = $signed({samp_rd[VALUE_BITS-1], samp_rd}) -
                 $signed({cen_rd[VALUE_BITS-1], cen_rd});
  assign mag   = diff[VALUE_BITS] ? (VALUE_BITS + 1)'(-diff) : diff;
  assign d_add = {1'b0, d_r} + {1'b0, sq_r};
  assign d_cur = p2_first_r ? sq_r : (d_add[DIST_BITS] ? '1 : d_add[DIST_BITS-1:0]);

  // accumulate: saturating sum update
  logic [SUM_BITS-1:0] sum_base;
  logic [SUM_BITS:0]   sum_add, sum_tot;

  assign sum_base = rv_r[best_r] ? sum_rd : '0;
  assign sum_add  = a1_use_r ? (SUM_BITS + 1)'($signed(samp_rd)) : '0;
  assign sum_tot  = {sum_base[SUM_BITS-1], sum_base} + sum_add;
  always_comb begin
    if (sum_tot[SUM_BITS] != sum_tot[SUM_BITS-1]) begin
      sum_wdata = sum_tot[SUM_BITS] ? {1'b1, {(SUM_BITS-1){1'b0}}}
                                    : {1'b0, {(SUM_BITS-1){1'b1}}};
    end else begin
      sum_wdata = sum_tot[SUM_BITS-1:0];
    end
  end

  logic [COUNT_BITS-1:0] cnt_val;
  assign cnt_val   = rv_r[c_r] ? cnt_rd : '0;
  assign cnt_we    = state_r == kle_pkg::ST_ACC_END;
  assign cnt_wdata = !rv_r[best_r] ? COUNT_BITS'(1) :
                     (&cnt_rd) ? cnt_rd : cnt_rd + 1'b1;

  // update: rounded mean through the divider
  logic [SUM_BITS-1:0]   sum_mag;
  logic [NB-1:0]         div_num, div_quo;
  logic                  div_start, div_done;
  logic [VALUE_BITS-1:0] mean;

  assign sum_mag   = sum_rd[SUM_BITS-1] ? SUM_BITS'(-sum_rd) : sum_rd;
  assign div_num   = {1'b0, sum_mag} + NB'(cnt_r >> 1);
  assign div_start = state_r == kle_pkg::ST_UPD_START;

  kle_div #(.NUM_BITS(NB), .DEN_BITS(COUNT_BITS)) u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .num(div_num), .den(cnt_r),
    .done(div_done), .quo(div_quo)
  );

  always_comb begin
    if (neg_r) begin
      mean = (div_quo > (NB'(1) << (VALUE_BITS - 1))) ? {1'b1, {(VALUE_BITS-1){1'b0}}}
                                                      : VALUE_BITS'(-div_quo);
    end else begin
      mean = (div_quo > ((NB'(1) << (VALUE_BITS - 1)) - NB'(1))) ?
             {1'b0, {(VALUE_BITS-1){1'b1}}} : div_quo[VALUE_BITS-1:0];
    end
  end

  always_comb begin
    if (state_r == kle_pkg::ST_UPD_DIV) begin
      cen_we    = div_done;
      cen_waddr = {c_r, j_r};
      cen_wdata = mean;
    end else begin
      cen_we    = in_fire && in_cmd == kle_pkg::CMD_LOAD && ci_ok && ei_ok;
      cen_waddr = {in_ci, in_ei};
      cen_wdata = in_val;
    end
  end

  // output register
  logic                 out_valid_r, out_kind_r;
  logic [CW-1:0]        out_near_r;
  logic [DIST_BITS-1:0] out_dist_r;
  logic [KW-1:0]        out_empty_r;
  logic                 out_load;

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_kind_r;
  assign out_tdata  = OUT_W'({out_empty_r, out_dist_r, out_near_r});

  // kind of the pending result, fixed when the command is taken
  logic d_kind_upd;
  logic upd_r;
  assign d_kind_upd = upd_r;

  always_ff @(posedge clk) begin
    if (in_fire) upd_r <= in_cmd == kle_pkg::CMD_UPDATE;
  end

  // state machine
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= kle_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_tready = 1'b0;
    out_load  = 1'b0;
    unique case (state_r)
      kle_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          if (in_cmd == kle_pkg::CMD_ASSIGN && in_tlast) begin
            state_nxt = kle_pkg::ST_DIST;
          end else if (in_cmd == kle_pkg::CMD_UPDATE) begin
            state_nxt = kle_pkg::ST_UPD_CNT;
          end
        end
      end
      kle_pkg::ST_DIST: begin
        if (j_last && c_last) state_nxt = kle_pkg::ST_DRAIN;
      end
      kle_pkg::ST_DRAIN: begin
        if (!p1_v_r && !p2_v_r) state_nxt = acc_r ? kle_pkg::ST_ACC : kle_pkg::ST_DONE;
      end
      kle_pkg::ST_ACC: begin
        if (acc_last) state_nxt = kle_pkg::ST_ACC_END;
      end
      kle_pkg::ST_ACC_END: state_nxt = kle_pkg::ST_DONE;
      kle_pkg::ST_UPD_CNT: state_nxt = kle_pkg::ST_UPD_CHK;
      kle_pkg::ST_UPD_CHK: begin
        if (cnt_val != '0) begin
          state_nxt = kle_pkg::ST_UPD_RD;
        end else begin
          state_nxt = c_last ? kle_pkg::ST_UPD_END : kle_pkg::ST_UPD_CNT;
        end
      end
      kle_pkg::ST_UPD_RD:    state_nxt = kle_pkg::ST_UPD_START;
      kle_pkg::ST_UPD_START: state_nxt = kle_pkg::ST_UPD_DIV;
      kle_pkg::ST_UPD_DIV: begin
        if (div_done) begin
          if (!j_last) begin
            state_nxt = kle_pkg::ST_UPD_RD;
          end else begin
            state_nxt = c_last ? kle_pkg::ST_UPD_END : kle_pkg::ST_UPD_CNT;
          end
        end
      end
      kle_pkg::ST_UPD_END: state_nxt = kle_pkg::ST_DONE;
      kle_pkg::ST_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_load  = 1'b1;
          state_nxt = kle_pkg::ST_IDLE;
        end
      end
      default: state_nxt = kle_pkg::ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r         <= KW'(1);
      len_r       <= NW'(1);
      rv_r        <= '0;
      out_valid_r <= 1'b0;
      p1_v_r      <= 1'b0;
      p2_v_r      <= 1'b0;
      a1_v_r      <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_addr)
          kle_pkg::REG_CLUSTER_COUNT: begin
            if (cfg_data == '0) k_r <= KW'(1);
            else if (cfg_data > CFG_W'(MAX_CLUSTERS)) k_r <= KW'(MAX_CLUSTERS);
            else k_r <= cfg_data[KW-1:0];
          end
          kle_pkg::REG_VECTOR_LENGTH: begin
            if (cfg_data == '0) len_r <= NW'(1);
            else if (cfg_data > CFG_W'(MAX_VECTOR_LENGTH)) len_r <= NW'(MAX_VECTOR_LENGTH);
            else len_r <= cfg_data[NW-1:0];
          end
          default: ;
        endcase
      end
      p1_v_r <= state_r == kle_pkg::ST_DIST;
      p2_v_r <= p1_v_r;
      a1_v_r <= state_r == kle_pkg::ST_ACC;
      if (state_r == kle_pkg::ST_ACC_END) rv_r[best_r] <= 1'b1;
      // the update empties all sums and counts at once
      if (state_r == kle_pkg::ST_UPD_END) rv_r <= '0;
      if (out_load) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    p1_first_r <= j_r == '0;
    p1_last_r  <= j_last;
    p1_c_r     <= c_r;
    p2_first_r <= p1_first_r;
    p2_last_r  <= p1_last_r;
    p2_c_r     <= p1_c_r;
    sq_r       <= DIST_BITS'(mag * mag);
    a1_j_r     <= j_r;
    a1_use_r   <= NW'(j_r) < len_r;

    if (p2_v_r) begin
      d_r <= d_cur;
      if (p2_last_r && (p2_c_r == '0 || d_cur < best_d_r)) begin
        best_d_r <= d_cur;
        best_r   <= p2_c_r;
      end
    end

    unique case (state_r)
      kle_pkg::ST_IDLE: begin
        c_r     <= '0;
        j_r     <= '0;
        acc_r   <= in_tuser;
        empty_r <= '0;
      end
      kle_pkg::ST_DIST: begin
        if (j_last) begin
          j_r <= '0;
          c_r <= c_r + 1'b1;
        end else begin
          j_r <= j_r + 1'b1;
        end
      end
      kle_pkg::ST_DRAIN: j_r <= '0;
      kle_pkg::ST_ACC:   j_r <= j_r + 1'b1;
      kle_pkg::ST_UPD_CHK: begin
        if (cnt_val == '0) begin
          empty_r <= empty_r + 1'b1;
          c_r     <= c_r + 1'b1;
        end else begin
          cnt_r <= cnt_val;
          j_r   <= '0;
        end
      end
      kle_pkg::ST_UPD_START: neg_r <= sum_rd[SUM_BITS-1];
      kle_pkg::ST_UPD_DIV: begin
        if (div_done) begin
          if (j_last) begin
            j_r <= '0;
            c_r <= c_r + 1'b1;
          end else begin
            j_r <= j_r + 1'b1;
          end
        end
      end
      default: ;
    endcase

    if (out_load) begin
      out_kind_r  <= (d_kind_upd) ? kle_pkg::RES_UPDATE : kle_pkg::RES_ASSIGN;
      out_near_r  <= d_kind_upd ? '0 : best_r;
      out_dist_r  <= d_kind_upd ? '0 : best_d_r;
      out_empty_r <= d_kind_upd ? empty_r : '0;
    end
  end

endmodule

[src/kle_chk.sv]
// kle_chk: port-level checks of the k-means engine, bound to the top level
// uses kle_pkg for the result kinds
module kle_chk #(
  parameter int MAX_CLUSTERS = kle_pkg::DEF_MAX_CLUSTERS,
  parameter int VALUE_BITS   = kle_pkg::DEF_VALUE_BITS,
  parameter int OUT_W        = 56
) (
  input logic             clk,
  input logic             rst_n,
  input logic             out_tvalid,
  input logic             out_tready,
  input logic [OUT_W-1:0] out_tdata,
  input logic             out_tuser,
  input logic             cfg_ready
);

  localparam int CW   = $clog2(MAX_CLUSTERS);
  localparam int KW   = $clog2(MAX_CLUSTERS + 1);
  localparam int DB   = 2 * VALUE_BITS + 6;
  localparam int LOW  = CW + DB;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  a_upd_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == kle_pkg::RES_UPDATE |->
      out_tdata[LOW-1:0] == '0 && out_tdata[LOW +: KW] <= KW'(MAX_CLUSTERS))
    else $error("update summary carries assignment fields");

  a_asg_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == kle_pkg::RES_ASSIGN |-> out_tdata[LOW +: KW] == '0)
    else $error("assignment result carries an empty count");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && cfg_ready)
    else $error("result or config port wrong after reset");

endmodule

bind kmeans_lloyd_engine_unit kle_chk #(
  .MAX_CLUSTERS(MAX_CLUSTERS),
  .VALUE_BITS(VALUE_BITS),
  .OUT_W(OUT_W)
) u_kle_chk (.*);
